/* hdl/hupl_pkg.sv */
// Shared types and constants for the hold upsampler with one-pole low-pass.
// No dependencies; used by hupl_ser_mul, the top level and the bench by scoped name.
package hupl_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int COUNT_BITS_DEF = 24;

    localparam int SAMPLE_W   = 16;
    localparam int RATIO_W    = 16;
    localparam int ALPHA_W    = 17;
    localparam int OCNT_W     = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam int MAX_RESULTS = 64;
    localparam int RES_CNT_W   = 7;
    localparam int ALPHA_ONE   = 65536;

    localparam int MUL_W     = 17;
    localparam int PROD_W    = 35;
    localparam int MUL_CNT_W = 5;

    localparam logic [RATIO_W-1:0] RATIO_RST = 16'd32768;
    localparam logic [ALPHA_W-1:0] ALPHA_RST = 17'd65536;
    localparam logic [OCNT_W-1:0]  OCNT_RST  = 24'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATIO     = 2'd0,
        CFG_ALPHA     = 2'd1,
        CFG_OUT_COUNT = 2'd2
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_UPDATE,
        ST_EMIT
    } t_state;

endpackage

/* hdl/hupl_ser_mul.sv */
// Bit-serial signed-by-unsigned multiplier, one multiplier bit per cycle.
// Depends on hupl_pkg for operand and product widths.
module hupl_ser_mul (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [hupl_pkg::MUL_W-1:0]   i_mcand,
    input  logic        [hupl_pkg::MUL_W-1:0]   i_mplier,
    output logic                                o_done,
    output logic signed [hupl_pkg::PROD_W-1:0]  o_product
);

    logic                                r_busy;
    logic                                r_done;
    logic [hupl_pkg::MUL_CNT_W-1:0]      r_cnt;
    logic [hupl_pkg::MUL_W:0]            r_hi;
    logic [hupl_pkg::MUL_W-1:0]          r_lo;
    logic [hupl_pkg::MUL_W-1:0]          r_mcand;
    logic [hupl_pkg::MUL_W-1:0]          r_mplier;

    logic [hupl_pkg::MUL_W+1:0]          addend;
    logic [hupl_pkg::MUL_W+1:0]          sum;
    logic [hupl_pkg::MUL_W:0]            n_hi;
    logic [hupl_pkg::MUL_W-1:0]          n_lo;

    always_comb begin
        addend = r_mplier[0] ? {{2{r_mcand[hupl_pkg::MUL_W-1]}}, r_mcand} : '0;
        sum    = {r_hi[hupl_pkg::MUL_W], r_hi} + addend;
        n_hi   = sum[hupl_pkg::MUL_W+1:1];
        n_lo   = {sum[0], r_lo[hupl_pkg::MUL_W-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == hupl_pkg::MUL_CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= hupl_pkg::MUL_CNT_W'(hupl_pkg::MUL_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - hupl_pkg::MUL_CNT_W'(1);
                if (r_cnt == hupl_pkg::MUL_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_hi     <= '0;
            r_lo     <= '0;
            r_mcand  <= i_mcand;
            r_mplier <= i_mplier;
        end else if (r_busy) begin
            r_hi     <= n_hi;
            r_lo     <= n_lo;
            r_mplier <= {1'b0, r_mplier[hupl_pkg::MUL_W-1:1]};
        end
    end

    assign o_done    = r_done;
    assign o_product = {r_hi, r_lo};

endmodule

/* hdl/hold_upsampler_one_pole_lowpass.sv */
// Hold upsampler with one-pole low-pass filter; top level.
// Depends on hupl_pkg and hupl_ser_mul.
// Each input passes through CHECK and, per output, through MUL, UPDATE and EMIT;
// MUL waits for the 17-step bit-serial multiplier and is skipped for the first
// output of a buffer. A new input is taken only in IDLE, after the last output
// of the previous input has been loaded into the output register.
// Reset: synchronous active-low; clears counters, phase, filter state and
// output valid, and loads the register defaults.
module hold_upsampler_one_pole_lowpass #(
    parameter int FRAC_BITS  = hupl_pkg::FRAC_BITS_DEF,
    parameter int COUNT_BITS = hupl_pkg::COUNT_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [hupl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [hupl_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [hupl_pkg::SAMPLE_W-1:0]      s_axis_tdata,  // [15:0] sample_in
    input  logic [0:0]                         s_axis_tuser,  // [0] first_in_buffer
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [hupl_pkg::SAMPLE_W-1:0]      m_axis_tdata,  // [15:0] sample_out
    output logic                               m_axis_tlast,
    output logic [0:0]                         m_axis_tuser   // [0] buffer_done
);

    localparam int PH_W  = COUNT_BITS + FRAC_BITS + 1;
    localparam int INT_W = COUNT_BITS + 1;
    localparam int SW    = hupl_pkg::SAMPLE_W;
    localparam logic [31:0] CNT_MAX = 32'((64'd1 << COUNT_BITS) - 64'd1);

    hupl_pkg::t_state                    r_state;
    hupl_pkg::t_state                    n_state;

    logic [hupl_pkg::RATIO_W-1:0]        r_ratio;
    logic [hupl_pkg::ALPHA_W-1:0]        r_alpha;
    logic [hupl_pkg::OCNT_W-1:0]         r_out_count;

    logic [COUNT_BITS-1:0]               r_in_idx;
    logic [COUNT_BITS-1:0]               r_out_idx;
    logic [PH_W-1:0]                     r_phase;
    logic [hupl_pkg::RES_CNT_W-1:0]      r_n;
    logic [SW-1:0]                       r_prev;
    logic                                r_m_valid;

    logic [SW-1:0]                       r_x;
    logic                                r_use_x;
    logic [SW-1:0]                       r_m_data;
    logic                                r_m_last;
    logic                                r_m_done;

    logic [COUNT_BITS-1:0]               n_in_idx;
    logic [COUNT_BITS-1:0]               n_out_idx;
    logic [PH_W-1:0]                     n_phase;
    logic [hupl_pkg::RES_CNT_W-1:0]      n_n;

    logic                                in_xfer;
    logic                                mul_start;
    logic                                mul_done;
    logic                                load_out;
    logic                                idx_step;
    logic                                out_free;
    logic                                more;
    logic                                buf_done;
    logic                                run_last;

    logic [31:0]                         limit_ext;
    logic [31:0]                         limit_c;
    logic [COUNT_BITS-1:0]               limit;
    logic [INT_W-1:0]                    phase_int;
    logic [INT_W-1:0]                    idx_ext;

    logic [hupl_pkg::ALPHA_W-1:0]        alpha_sat;
    logic signed [hupl_pkg::MUL_W-1:0]   diff;
    logic signed [hupl_pkg::PROD_W-1:0]  product;
    logic [SW+3:0]                       q;
    logic [SW+3:0]                       filt;
    logic                                frac_nz;
    logic [SW-1:0]                       y;

    assign o_cfg_ready = 1'b1;
    assign in_xfer     = s_axis_tvalid && s_axis_tready;
    assign out_free    = !r_m_valid || m_axis_tready;

    always_comb begin
        limit_ext = {{(32 - hupl_pkg::OCNT_W){1'b0}}, r_out_count};
        limit_c   = (limit_ext > CNT_MAX) ? CNT_MAX : limit_ext;
        limit     = limit_c[COUNT_BITS-1:0];
        phase_int = r_phase[PH_W-1:FRAC_BITS];
        idx_ext   = {1'b0, r_in_idx};
        more      = (r_n < hupl_pkg::RES_CNT_W'(hupl_pkg::MAX_RESULTS))
                    && (r_out_idx < limit) && (phase_int <= idx_ext);
        buf_done  = (r_out_idx == limit);
        run_last  = buf_done || (r_n == hupl_pkg::RES_CNT_W'(hupl_pkg::MAX_RESULTS))
                    || (phase_int > idx_ext);
    end

    always_comb begin
        alpha_sat = (r_alpha > hupl_pkg::ALPHA_W'(hupl_pkg::ALPHA_ONE))
                    ? hupl_pkg::ALPHA_W'(hupl_pkg::ALPHA_ONE) : r_alpha;
        diff      = {r_x[SW-1], r_x} - {r_prev[SW-1], r_prev};
        q         = {{4{r_prev[SW-1]}}, r_prev}
                    + {product[hupl_pkg::PROD_W-1], product[hupl_pkg::PROD_W-1:SW]};
        frac_nz   = |product[SW-1:0];
        filt      = q + (SW+4)'(q[SW+3] && frac_nz);
        y         = r_use_x ? r_x : filt[SW-1:0];
    end

    hupl_ser_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_mcand   (diff),
        .i_mplier  (alpha_sat),
        .o_done    (mul_done),
        .o_product (product)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hupl_pkg::ST_IDLE: begin
                if (in_xfer) n_state = hupl_pkg::ST_CHECK;
            end
            hupl_pkg::ST_CHECK: begin
                if (!more) begin
                    n_state = hupl_pkg::ST_IDLE;
                end else if (r_out_idx == '0) begin
                    n_state = hupl_pkg::ST_UPDATE;
                end else begin
                    n_state = hupl_pkg::ST_MUL;
                end
            end
            hupl_pkg::ST_MUL: begin
                if (mul_done) n_state = hupl_pkg::ST_UPDATE;
            end
            hupl_pkg::ST_UPDATE: begin
                n_state = hupl_pkg::ST_EMIT;
            end
            hupl_pkg::ST_EMIT: begin
                if (out_free) n_state = hupl_pkg::ST_CHECK;
            end
            default: begin
                n_state = hupl_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == hupl_pkg::ST_IDLE);
        mul_start     = (r_state == hupl_pkg::ST_CHECK) && more && (r_out_idx != '0);
        idx_step      = (r_state == hupl_pkg::ST_CHECK) && !more;
        load_out      = (r_state == hupl_pkg::ST_EMIT) && out_free;
    end

    always_comb begin
        n_in_idx  = r_in_idx;
        n_out_idx = r_out_idx;
        n_phase   = r_phase;
        n_n       = r_n;
        if (in_xfer) begin
            n_n = '0;
            if (s_axis_tuser[0]) begin
                n_in_idx  = '0;
                n_out_idx = '0;
                n_phase   = '0;
            end
        end
        if (idx_step && (r_in_idx != '1)) begin
            n_in_idx = r_in_idx + COUNT_BITS'(1);
        end
        if (r_state == hupl_pkg::ST_UPDATE) begin
            n_phase   = r_phase + PH_W'(r_ratio);
            n_out_idx = r_out_idx + COUNT_BITS'(1);
            n_n       = r_n + hupl_pkg::RES_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hupl_pkg::ST_IDLE;
            r_ratio     <= hupl_pkg::RATIO_RST;
            r_alpha     <= hupl_pkg::ALPHA_RST;
            r_out_count <= hupl_pkg::OCNT_RST;
            r_in_idx    <= '0;
            r_out_idx   <= '0;
            r_phase     <= '0;
            r_n         <= '0;
            r_prev      <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_in_idx  <= n_in_idx;
            r_out_idx <= n_out_idx;
            r_phase   <= n_phase;
            r_n       <= n_n;
            if (r_state == hupl_pkg::ST_UPDATE) begin
                r_prev <= y;
            end
            if (load_out) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (hupl_pkg::t_cfg_reg'(i_cfg_index))
                    hupl_pkg::CFG_RATIO:     r_ratio     <= i_cfg_data[hupl_pkg::RATIO_W-1:0];
                    hupl_pkg::CFG_ALPHA:     r_alpha     <= i_cfg_data[hupl_pkg::ALPHA_W-1:0];
                    hupl_pkg::CFG_OUT_COUNT: r_out_count <= i_cfg_data[hupl_pkg::OCNT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_x <= s_axis_tdata;
        end
        if (r_state == hupl_pkg::ST_CHECK) begin
            r_use_x <= (r_out_idx == '0);
        end
        if (load_out) begin
            r_m_data <= r_prev;
            r_m_last <= run_last;
            r_m_done <= buf_done;
        end
    end

    assign m_axis_tvalid   = r_m_valid;
    assign m_axis_tdata    = r_m_data;
    assign m_axis_tlast    = r_m_last;
    assign m_axis_tuser[0] = r_m_done;

endmodule

/* hdl/hupl_chk.sv */
// Port-level checks for the hold upsampler top level, attached by bind.
// Depends only on the top level's ports.
module hupl_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [0:0]  m_axis_tuser
);

    a_rst_clears_valid: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid set right after reset");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("buffer end without end of run");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a transfer");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("output payload changed while stalled");

endmodule

bind hold_upsampler_one_pole_lowpass hupl_chk u_hupl_chk (.*);

/* verif/tb.sv */
// Self-checking bench for hold_upsampler_one_pole_lowpass: stream samples, predict
// the held and low-pass filtered outputs, and compare each output transfer.
// Depends on hupl_pkg and the RTL of the block; needs nothing else.
module tb;

    localparam int SETTLE_CYCLES    = 64;
    localparam int CYCLE_LIMIT      = 3_000_000;
    localparam int ITEMS_PER_PHASE  = 24;
    localparam logic [23:0] IDX_SAT = 24'hFFFFFF;

    typedef struct packed {
        logic [15:0] sample;
        logic        run_last;
        logic        buffer_done;
    } t_out_sample;

    typedef enum {ROW_CFG, ROW_SAMPLE} t_row_kind;
    typedef enum {CHK_MODEL, CHK_NONE, CHK_ONE} t_check_kind;
    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    typedef struct {
        t_row_kind          kind;
        hupl_pkg::t_cfg_reg sel;
        logic [23:0]        value;
        logic [15:0]        smp;
        logic               first;
        t_check_kind        chk;
        t_out_sample        typed_out;
    } t_dir_row;

    logic               i_clk;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_valid   = 1'b0;
    logic               o_cfg_ready;
    hupl_pkg::t_cfg_reg i_cfg_index   = hupl_pkg::CFG_RATIO;
    logic [23:0]        i_cfg_data    = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [15:0]        s_axis_tdata  = '0;
    logic [0:0]         s_axis_tuser  = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [15:0]        m_axis_tdata;
    logic               m_axis_tlast;
    logic [0:0]         m_axis_tuser;

    hold_upsampler_one_pole_lowpass dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // predictor copy of registers and state
    logic [15:0]        step_ratio  = hupl_pkg::RATIO_RST;
    logic [16:0]        mix_alpha   = hupl_pkg::ALPHA_RST;
    logic [23:0]        buffer_len  = hupl_pkg::OCNT_RST;
    logic [23:0]        src_idx     = '0;
    logic [39:0]        phase_q     = '0;
    logic [23:0]        dst_idx     = '0;
    logic signed [15:0] last_y      = '0;

    t_out_sample pending_outputs[$];
    t_out_sample fresh_outputs[$];
    t_dir_row    directed_rows[$];
    t_out_sample seen_out;
    t_out_sample want_out;

    int mismatches   = 0;
    int cycle_count  = 0;
    int send_idle    = 0;
    int recv_stall   = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d outputs pending",
                     cycle_count, pending_outputs.size());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // check output transfers, then pick the next ready
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_out = {m_axis_tdata, m_axis_tlast, m_axis_tuser[0]};
            if (pending_outputs.size() == 0) begin
                report_mismatch($sformatf("unexpected output %h", seen_out));
            end else begin
                want_out = pending_outputs.pop_front();
                if (seen_out.sample !== want_out.sample)
                    report_mismatch($sformatf("sample_out %h, want %h",
                                              seen_out.sample, want_out.sample));
                if (seen_out.run_last !== want_out.run_last)
                    report_mismatch($sformatf("run_last %b, want %b",
                                              seen_out.run_last, want_out.run_last));
                if (seen_out.buffer_done !== want_out.buffer_done)
                    report_mismatch($sformatf("buffer_done %b, want %b",
                                              seen_out.buffer_done,
                                              want_out.buffer_done));
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall);
    end

    function automatic void upsample_filter_step(input logic [15:0] smp_bits,
                                                 input logic first);
        int                 n;
        longint             wt;
        longint             acc;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               done_f;
        logic               last_f;
        n = 0;
        x = smp_bits;
        if (first) begin
            src_idx = '0;
            phase_q = '0;
            dst_idx = '0;
        end
        while (n < hupl_pkg::MAX_RESULTS && dst_idx < buffer_len &&
               (phase_q >> hupl_pkg::FRAC_BITS_DEF) <= src_idx) begin
            if (dst_idx == 0) begin
                y = x;
            end else begin
                wt  = (mix_alpha > hupl_pkg::ALPHA_ONE) ? hupl_pkg::ALPHA_ONE : mix_alpha;
                acc = wt * longint'(x)
                      + (longint'(hupl_pkg::ALPHA_ONE) - wt) * longint'(last_y);
                y   = 16'(acc / hupl_pkg::ALPHA_ONE);
            end
            last_y  = y;
            phase_q = phase_q + step_ratio;
            dst_idx = dst_idx + 24'd1;
            done_f  = (dst_idx == buffer_len);
            last_f  = done_f || (n + 1 == hupl_pkg::MAX_RESULTS) ||
                      ((phase_q >> hupl_pkg::FRAC_BITS_DEF) > src_idx);
            fresh_outputs.push_back({y, last_f, done_f});
            n++;
        end
        if (src_idx != IDX_SAT)
            src_idx = src_idx + 24'd1;
    endfunction

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin send_idle = 0;  recv_stall = 0;  end
            IDLE_SEND: begin send_idle = 88; recv_stall = 0;  end
            IDLE_RECV: begin send_idle = 0;  recv_stall = 88; end
            default:   begin send_idle = 7;  recv_stall = 7;  end
        endcase
    endtask

    // hold input off until every pending output has arrived and the block is quiet
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input hupl_pkg::t_cfg_reg sel, input logic [23:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (sel)
            hupl_pkg::CFG_RATIO:     step_ratio = value[15:0];
            hupl_pkg::CFG_ALPHA:     mix_alpha  = value[16:0];
            hupl_pkg::CFG_OUT_COUNT: buffer_len = value;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic feed_sample(input logic [15:0] smp, input logic first,
                               input t_check_kind chk, input t_out_sample typed_out);
        if ($urandom_range(0, 99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < send_idle) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tuser  <= first;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        fresh_outputs.delete();
        upsample_filter_step(smp, first);
        case (chk)
            CHK_MODEL: foreach (fresh_outputs[k]) pending_outputs.push_back(fresh_outputs[k]);
            CHK_ONE:   pending_outputs.push_back(typed_out);
            default: ;
        endcase
    endtask

    function automatic void add_cfg(input hupl_pkg::t_cfg_reg sel, input logic [23:0] value);
        t_dir_row r;
        r.kind      = ROW_CFG;
        r.sel       = sel;
        r.value     = value;
        r.smp       = '0;
        r.first     = 1'b0;
        r.chk       = CHK_NONE;
        r.typed_out = '0;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_smp(input logic [15:0] smp, input logic first,
                                    input t_check_kind chk, input t_out_sample typed_out);
        t_dir_row r;
        r.kind      = ROW_SAMPLE;
        r.sel       = hupl_pkg::CFG_RATIO;
        r.value     = '0;
        r.smp       = smp;
        r.first     = first;
        r.chk       = chk;
        r.typed_out = typed_out;
        directed_rows.push_back(r);
    endfunction

    function automatic logic [15:0] pick_sample();
        logic [15:0] extremes[4];
        extremes = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
        if ($urandom_range(0, 99) < 15)
            return extremes[$urandom_range(0, 3)];
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] pick_ratio();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 67) return 16'($urandom_range(16384, 65535));
        if (roll < 87) return 16'($urandom_range(4096, 16383));
        if (roll < 97) return 16'($urandom_range(1024, 4095));
        return 16'($urandom_range(0, 1023));
    endfunction

    function automatic logic [16:0] pick_alpha();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) return 17'($urandom_range(0, 65536));
        if (roll < 90) return 17'(hupl_pkg::ALPHA_ONE);
        return 17'($urandom_range(65537, 131071));
    endfunction

    function automatic logic [23:0] pick_count();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return 24'($urandom_range(1, 40));
        if (roll < 80) return 24'd0;
        if (roll < 90) return IDX_SAT;
        return 24'($urandom);
    endfunction

    initial begin
        int          phase_no;
        int          fed_items;
        int          run_len;
        logic        first;
        logic [15:0] smp;

        // reset defaults: ratio one half, alpha one, one output per buffer
        add_smp(16'h7FFF, 1'b1, CHK_ONE,  {16'h7FFF, 1'b1, 1'b1});
        add_smp(16'h0000, 1'b0, CHK_NONE, '0);
        add_smp(16'h8000, 1'b1, CHK_ONE,  {16'h8000, 1'b1, 1'b1});
        add_cfg(hupl_pkg::CFG_OUT_COUNT, 24'd0);
        add_smp(16'h1234, 1'b1, CHK_NONE, '0);
        add_cfg(hupl_pkg::CFG_OUT_COUNT, 24'hFFFFFF);
        add_cfg(hupl_pkg::CFG_RATIO, 24'hFFFFFF);
        add_cfg(hupl_pkg::CFG_ALPHA, 24'h000000);
        add_smp(16'd100,  1'b1, CHK_MODEL, '0);
        add_smp(16'hFFFB, 1'b0, CHK_MODEL, '0);
        add_smp(16'h8000, 1'b0, CHK_MODEL, '0);
        // alpha above one, then the cap of results per input
        add_cfg(hupl_pkg::CFG_ALPHA, 24'h01FFFF);
        add_cfg(hupl_pkg::CFG_RATIO, 24'd1024);
        add_smp(16'h7FFF, 1'b1, CHK_MODEL, '0);
        add_smp(16'h8000, 1'b0, CHK_MODEL, '0);
        add_cfg(hupl_pkg::CFG_RATIO, 24'd0);
        add_smp(16'd7,    1'b0, CHK_MODEL, '0);
        add_smp(16'hFFF9, 1'b0, CHK_MODEL, '0);
        // lagging phase catches up, buffer ends inside a run
        add_cfg(hupl_pkg::CFG_RATIO, 24'd1000);
        add_cfg(hupl_pkg::CFG_ALPHA, 24'd30000);
        add_cfg(hupl_pkg::CFG_OUT_COUNT, 24'd100);
        add_smp(16'd20000, 1'b1, CHK_MODEL, '0);
        add_smp(16'hB1E0,  1'b0, CHK_MODEL, '0);
        add_smp(16'h0000,  1'b0, CHK_MODEL, '0);
        add_smp(16'd5,     1'b0, CHK_MODEL, '0);
        add_smp(16'd9,     1'b0, CHK_MODEL, '0);
        // negative sums truncate toward zero; alpha changes mid-buffer
        add_cfg(hupl_pkg::CFG_RATIO, 24'd32768);
        add_cfg(hupl_pkg::CFG_ALPHA, 24'd20000);
        add_cfg(hupl_pkg::CFG_OUT_COUNT, 24'd10);
        add_smp(16'h8AD0, 1'b1, CHK_MODEL, '0);
        add_smp(16'd12345, 1'b0, CHK_MODEL, '0);
        add_smp(16'hFFFF, 1'b0, CHK_MODEL, '0);
        add_cfg(hupl_pkg::CFG_ALPHA, 24'd65535);
        add_smp(16'd1,    1'b0, CHK_MODEL, '0);
        add_smp(16'h7FFF, 1'b0, CHK_MODEL, '0);
        add_smp(16'h8000, 1'b0, CHK_MODEL, '0);
        add_smp(16'd42,   1'b1, CHK_MODEL, '0);

        set_idling(IDLE_BOTH);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                settle_block();
                cfg_write(directed_rows[i].sel, directed_rows[i].value);
            end else begin
                feed_sample(directed_rows[i].smp, directed_rows[i].first,
                            directed_rows[i].chk, directed_rows[i].typed_out);
            end
        end

        for (phase_no = 0; phase_no < 4; phase_no++) begin
            set_idling(t_idle_mode'(phase_no));
            fed_items = 0;
            while (fed_items < ITEMS_PER_PHASE) begin
                if (fed_items == 0 || $urandom_range(0, 2) == 0) begin
                    settle_block();
                    cfg_write(hupl_pkg::CFG_RATIO, {8'($urandom), pick_ratio()});
                    cfg_write(hupl_pkg::CFG_ALPHA, {7'($urandom), pick_alpha()});
                    cfg_write(hupl_pkg::CFG_OUT_COUNT, pick_count());
                end
                run_len = $urandom_range(1, 12);
                for (int k = 0; k < run_len; k++) begin
                    // mostly well-formed buffers; now and then a stray restart or none
                    if (k == 0)
                        first = ($urandom_range(0, 9) != 0);
                    else
                        first = ($urandom_range(0, 19) == 0);
                    smp = pick_sample();
                    feed_sample(smp, first, CHK_MODEL, '0);
                    fed_items++;
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
